### design/imu_attitude_time_interpolator_core_assert.svh
// ----------------------------------------------------------------------------
// IMU attitude interpolator assertion macros
// Shared assertion forms for the checker files of this block.
// ----------------------------------------------------------------------------
`ifndef IMU_ATTITUDE_TIME_INTERPOLATOR_CORE_ASSERT_SVH
`define IMU_ATTITUDE_TIME_INTERPOLATOR_CORE_ASSERT_SVH

// Property checked outside reset.
`define IATI_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define IATI_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/iati_pkg.sv
// ----------------------------------------------------------------------------
// IMU attitude interpolator package
// Sample type and fixed-point constants used by the core.
// ----------------------------------------------------------------------------
package iati_pkg;

	// Pi and two pi in Q3.13 radians.
	localparam int PI_Q     = 25736;
	localparam int TWO_PI_Q = 51472;
	// Rounding offset for the Q1.16 weight product.
	localparam int HALF_Q16 = 32768;
	localparam logic [16:0] WF_ONE = 17'h10000;

	typedef struct packed {
		logic        [31:0] stamp;
		logic signed [15:0] roll;
		logic signed [15:0] pitch;
		logic signed [15:0] yaw;
	} sample_t;

	localparam int SAMPLE_W = $bits(sample_t);

endpackage

### design/iati_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module iati_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/imu_attitude_time_interpolator_core.sv
// ----------------------------------------------------------------------------
// IMU attitude time interpolator core
// Ring of timestamped roll, pitch and yaw samples with linear interpolation.
// ----------------------------------------------------------------------------
// A push keeps busy high for 1 cycle; the next push waits until it is written.
// A query scans the ring from the last search position; beyond the newest sample
// it returns that sample, else it reads the older neighbor, runs the restoring
// divider unless the weight is known, and blends on the shared multiplier;
// result_valid pulses for one cycle as busy drops.
// The receiver cannot stall, so the next transaction may start at once.
// Reset clears sequencer, pointers and fill count; the ring reads as zero until written.
// ----------------------------------------------------------------------------
module imu_attitude_time_interpolator_core #(
	parameter int QUEUE_DEPTH = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               kind,
	input  logic        [31:0] sample_time,
	input  logic signed [15:0] roll_in,
	input  logic signed [15:0] pitch_in,
	input  logic signed [15:0] yaw_in,
	input  logic        [31:0] scan_start,
	input  logic        [19:0] point_offset,
	output logic               result_valid,
	output logic signed [15:0] roll_out,
	output logic signed [15:0] pitch_out,
	output logic signed [17:0] yaw_out,
	output logic               beyond_newest
);
	import iati_pkg::*;

	localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam logic [AW-1:0] LAST_IDX = AW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

	// Sequencer states.
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_PUSH = 3'd1;
	localparam logic [2:0] S_RDF  = 3'd2;
	localparam logic [2:0] S_CHKF = 3'd3;
	localparam logic [2:0] S_RDB  = 3'd4;
	localparam logic [2:0] S_CHKB = 3'd5;
	localparam logic [2:0] S_DIV  = 3'd6;
	localparam logic [2:0] S_MUL  = 3'd7;

	logic [2:0]    state_q;
	logic [AW-1:0] newest_q, search_q, cur_q;
	logic [CW-1:0] count_q;
	logic [32:0]   t_q;
	sample_t       push_q, front_q, back_q;
	logic signed [17:0] yb_q;
	logic [31:0]   rem_q, d_q;
	logic [15:0]   quo_q;
	logic [4:0]    step_q;
	logic [16:0]   wf_q;
	logic [1:0]    mi_q;
	logic signed [36:0] prod_q;
	logic signed [17:0] base_q;
	logic          res_valid_q, beyond_q;
	logic signed [15:0] roll_q, pitch_q;
	logic signed [17:0] yaw_q;

	logic [AW-1:0] newest_next, cur_next, back_idx, raddr, raddr_s1;
	logic [SAMPLE_W-1:0] ram_rdata;
	sample_t       rd_sample;
	logic          rd_ok, accept;

	// Ring index arithmetic with explicit wrap for any depth.
	assign newest_next = (newest_q == LAST_IDX) ? '0 : newest_q + 1'b1;
	assign cur_next    = (cur_q == LAST_IDX) ? '0 : cur_q + 1'b1;
	assign back_idx    = (cur_q == '0) ? LAST_IDX : cur_q - 1'b1;

	assign raddr  = (state_q == S_RDB) ? back_idx : cur_q;
	assign accept = start && (state_q == S_IDLE);
	assign busy   = (state_q != S_IDLE);

	iati_ram #(
		.WIDTH (SAMPLE_W),
		.DEPTH (QUEUE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (state_q == S_PUSH),
		.waddr (newest_next),
		.wdata (push_q),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// Pushes fill entries 1, 2, ... and wrap to entry 0 last, so a fill
	// count tells which entries still hold their zero reset value.
	always_ff @(posedge clk) begin
		raddr_s1 <= raddr;
	end

	assign rd_ok = (count_q == FULL_CNT) ||
		((raddr_s1 != '0) && (CW'(raddr_s1) <= count_q));
	assign rd_sample = rd_ok ? sample_t'(ram_rdata) : '0;

	// Yaw unwrap of the older neighbor against the newer one.
	logic signed [16:0] yaw_gap;
	logic signed [17:0] yb_adj;
	assign yaw_gap = 17'(front_q.yaw) - 17'(rd_sample.yaw);
	always_comb begin
		yb_adj = 18'(rd_sample.yaw);
		priority if (yaw_gap > 17'(PI_Q)) begin
			yb_adj = 18'(rd_sample.yaw) + 18'(TWO_PI_Q);
		end else if (yaw_gap < -17'(PI_Q)) begin
			yb_adj = 18'(rd_sample.yaw) - 18'(TWO_PI_Q);
		end
	end

	// Restoring divider step.
	logic [32:0] trial;
	logic        ge;
	assign trial = (step_q == '0) ? {1'b0, rem_q} : {rem_q, 1'b0};
	assign ge    = (trial >= {1'b0, d_q});

	// Shared multiplier operands: one angle per cycle.
	logic signed [17:0] fa, ba;
	logic signed [18:0] adiff;
	logic signed [17:0] blended;
	always_comb begin
		unique case (mi_q)
			2'd0: begin
				fa = 18'(front_q.roll);
				ba = 18'(back_q.roll);
			end
			2'd1: begin
				fa = 18'(front_q.pitch);
				ba = 18'(back_q.pitch);
			end
			default: begin
				fa = 18'(front_q.yaw);
				ba = yb_q;
			end
		endcase
	end
	assign adiff   = 19'(fa) - 19'(ba);
	assign blended = base_q + 18'((prod_q + 37'(HALF_Q16)) >>> 16);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			newest_q    <= '0;
			search_q    <= '0;
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			res_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= kind ? S_RDF : S_PUSH;
					end
				end
				S_PUSH: begin
					newest_q <= newest_next;
					if (count_q != FULL_CNT) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_RDF: begin
					state_q <= S_CHKF;
				end
				S_CHKF: begin
					if ((cur_q == newest_q) || (t_q < {1'b0, rd_sample.stamp})) begin
						search_q <= cur_q;
						if (t_q > {1'b0, rd_sample.stamp}) begin
							res_valid_q <= 1'b1;
							state_q     <= S_IDLE;
						end else begin
							state_q <= S_RDB;
						end
					end else begin
						state_q <= S_RDF;
					end
				end
				S_RDB: begin
					state_q <= S_CHKB;
				end
				S_CHKB: begin
					if ((front_q.stamp <= rd_sample.stamp) ||
						(t_q <= {1'b0, rd_sample.stamp})) begin
						state_q <= S_MUL;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (step_q == 5'd16) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					if (mi_q == 2'd3) begin
						res_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				t_q          <= {1'b0, scan_start} + {13'b0, point_offset};
				push_q.stamp <= sample_time;
				push_q.roll  <= roll_in;
				push_q.pitch <= pitch_in;
				push_q.yaw   <= yaw_in;
				cur_q        <= search_q;
			end
			S_CHKF: begin
				front_q <= rd_sample;
				if (!((cur_q == newest_q) || (t_q < {1'b0, rd_sample.stamp}))) begin
					cur_q <= cur_next;
				end else if (t_q > {1'b0, rd_sample.stamp}) begin
					roll_q   <= rd_sample.roll;
					pitch_q  <= rd_sample.pitch;
					yaw_q    <= 18'(rd_sample.yaw);
					beyond_q <= 1'b1;
				end
			end
			S_CHKB: begin
				back_q   <= rd_sample;
				yb_q     <= yb_adj;
				rem_q    <= 32'(t_q - {1'b0, rd_sample.stamp});
				d_q      <= front_q.stamp - rd_sample.stamp;
				step_q   <= '0;
				mi_q     <= '0;
				beyond_q <= 1'b0;
				if (front_q.stamp <= rd_sample.stamp) begin
					wf_q <= WF_ONE;
				end else begin
					wf_q <= '0;
				end
			end
			S_DIV: begin
				rem_q  <= ge ? 32'(trial - {1'b0, d_q}) : trial[31:0];
				quo_q  <= {quo_q[14:0], ge};
				step_q <= step_q + 1'b1;
				if (step_q == 5'd16) begin
					wf_q <= {quo_q, ge};
				end
			end
			S_MUL: begin
				prod_q <= 37'(adiff) * $signed({1'b0, wf_q});
				base_q <= ba;
				mi_q   <= mi_q + 1'b1;
				unique case (mi_q)
					2'd1: roll_q  <= 16'(blended);
					2'd2: pitch_q <= 16'(blended);
					2'd3: yaw_q   <= blended;
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	assign result_valid  = res_valid_q;
	assign roll_out      = roll_q;
	assign pitch_out     = pitch_q;
	assign yaw_out       = yaw_q;
	assign beyond_newest = beyond_q;

endmodule

### design/iati_checker.sv
// ----------------------------------------------------------------------------
// IMU attitude interpolator checker
// Port-level temporal checks, bound to the core.
// ----------------------------------------------------------------------------
`include "imu_attitude_time_interpolator_core_assert.svh"

module iati_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic kind,
	input logic result_valid
);

	`IATI_ASSERT(a_accept_busy, start && !busy |=> busy, "busy not raised after a transaction")
	`IATI_ASSERT(a_push_silent, start && !busy && !kind |=> !result_valid, "push gave a result")
	`IATI_ASSERT(a_single_pulse, result_valid |=> !result_valid, "result strobe longer than one cycle")
	`IATI_ASSERT(a_done_idle, result_valid |-> !busy, "result shown while still busy")
	`IATI_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> !busy && !result_valid, "not idle in reset")

endmodule

bind imu_attitude_time_interpolator_core iati_checker u_iati_checker (.*);
